// ===== rtl/gtf_pkg.sv =====
// ----------------------------------------------------------------------------
// gtf_pkg
// Shared types, constants and small tables of the gammatone filter channel.
// ----------------------------------------------------------------------------
package gtf_pkg;

	// default trig table resolution (phase index steps per turn)
	localparam int COS_TABLE_DEPTH_DEF = 1024;

	// pi/2 in Q30 and unity in Q30
	localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
	localparam logic [30:0] Q30_ONE     = 31'h4000_0000;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_POLE_DECAY  = 2'd0,
		REG_PHASE_STEP  = 2'd1,
		REG_OUTPUT_GAIN = 2'd2
	} reg_index_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ANGLE,
		ST_SERIES,
		ST_SIN_FIN,
		ST_QUAD,
		ST_MIX,
		ST_REC,
		ST_DOUT,
		ST_GAIN,
		ST_SQRT,
		ST_WRITE
	} state_t;

	// taylor series divisor for term k = kidx + 1
	function automatic logic [8:0] series_den(input logic odd, input logic [2:0] kidx);
		logic [8:0] d;
		d = 9'd0;
		case ({odd, kidx})
			4'b1_000: d = 9'd6;
			4'b1_001: d = 9'd20;
			4'b1_010: d = 9'd42;
			4'b1_011: d = 9'd72;
			4'b1_100: d = 9'd110;
			4'b1_101: d = 9'd156;
			4'b1_110: d = 9'd210;
			4'b1_111: d = 9'd272;
			4'b0_000: d = 9'd2;
			4'b0_001: d = 9'd12;
			4'b0_010: d = 9'd30;
			4'b0_011: d = 9'd56;
			4'b0_100: d = 9'd90;
			4'b0_101: d = 9'd132;
			4'b0_110: d = 9'd182;
			4'b0_111: d = 9'd240;
			default:  d = 9'd2;
		endcase
		return d;
	endfunction

	// floor(2^32 / divisor), used as a reciprocal with one correction step
	function automatic logic [31:0] series_recip(input logic odd, input logic [2:0] kidx);
		logic [31:0] r;
		r = 32'd0;
		case ({odd, kidx})
			4'b1_000: r = 32'd715827882;
			4'b1_001: r = 32'd214748364;
			4'b1_010: r = 32'd102261126;
			4'b1_011: r = 32'd59652323;
			4'b1_100: r = 32'd39045157;
			4'b1_101: r = 32'd27531841;
			4'b1_110: r = 32'd20452225;
			4'b1_111: r = 32'd15790320;
			4'b0_000: r = 32'd2147483648;
			4'b0_001: r = 32'd357913941;
			4'b0_010: r = 32'd143165576;
			4'b0_011: r = 32'd76695844;
			4'b0_100: r = 32'd47721858;
			4'b0_101: r = 32'd32537631;
			4'b0_110: r = 32'd23598721;
			4'b0_111: r = 32'd17895697;
			default:  r = 32'd2147483648;
		endcase
		return r;
	endfunction

	// saturate to 44 bits signed
	function automatic logic signed [43:0] sat44(input logic signed [46:0] v);
		logic signed [43:0] r;
		if ((v[46:43] == 4'b0000) || (v[46:43] == 4'b1111))
			r = v[43:0];
		else if (v[46])
			r = {1'b1, 43'd0};
		else
			r = {1'b0, {43{1'b1}}};
		return r;
	endfunction

	// saturate to 40 bits signed
	function automatic logic signed [39:0] sat40(input logic signed [46:0] v);
		logic signed [39:0] r;
		if ((v[46:39] == 8'h00) || (v[46:39] == 8'hFF))
			r = v[39:0];
		else if (v[46])
			r = {1'b1, 39'd0};
		else
			r = {1'b0, {39{1'b1}}};
		return r;
	endfunction

endpackage

// ===== rtl/gammatone_filter_channel_top.sv =====
// A new sample request is accepted only in idle, after the previous result has gone to the output register;
// a single 32x32 multiplier is shared by the trig series, the pole recursions,
// remodulation and gain, and the square root runs one bit pair per cycle.
// Reset: arst_n clears configuration registers, histories, phase and control, no clearing pass.
// ----------------------------------------------------------------------------
// gammatone_filter_channel_top
// One channel of a fourth-order gammatone filter by complex demodulation,
// computed by a small sequencer around one shared multiplier.
// ----------------------------------------------------------------------------
module gammatone_filter_channel_top #(
	parameter int COS_TABLE_DEPTH = gtf_pkg::COS_TABLE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] sample
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // [15:0] filtered, [31:16] envelope_root
);

	localparam int IDX_BITS = $clog2(COS_TABLE_DEPTH);
	localparam logic [29:0] ANGLE_MASK = ~((30'd1 << (32 - IDX_BITS)) - 30'd1);

	gtf_pkg::state_t state_q, state_d;
	logic [2:0] ph_q, ph_d, ph_end;

	logic [2:0] kidx_q, st_q;
	logic       odd_q, side_q;
	logic [3:0] cnt_q;

	logic [31:0] pole_q, step_q, phase_q;
	logic [47:0] gain_q;

	logic signed [39:0] real_h [4];
	logic signed [39:0] imag_h [4];
	logic signed [39:0] cur_h  [4];

	logic [31:0] mul_a, mul_b;
	logic [63:0] prod_q;

	logic signed [15:0] x_q;
	logic [31:0] angle_q;
	logic [30:0] a_q, s_q;
	logic [31:0] a2_q, p_q, q0_q;
	logic [17:0] sq_q, cq_q;
	logic signed [18:0] cv_q, sv_q;
	logic signed [19:0] mixr_q, mixi_q;
	logic signed [43:0] t_q;
	logic [32:0] lowr_q;
	logic signed [39:0] newv_q;
	logic signed [44:0] u_q, v_q;
	logic signed [63:0] acc_q;
	logic [61:0] dmag_q;
	logic        dneg_q;
	logic [111:0] bacc_q;
	logic signed [15:0] filt_q;
	logic [31:0] sq_v_q, sq_r_q, sq_bit_q;
	logic signed [15:0] out_filt_q;
	logic [15:0] out_env_q;
	logic        out_valid_q;

	// magnitudes of signed operands
	logic [15:0] x_mag;
	logic [18:0] cv_mag, sv_mag;
	logic [43:0] t_mag;
	logic [44:0] u_mag, v_mag;

	assign x_mag  = x_q[15]  ? 16'(-x_q)  : 16'(x_q);
	assign cv_mag = cv_q[18] ? 19'(-cv_q) : 19'(cv_q);
	assign sv_mag = sv_q[18] ? 19'(-sv_q) : 19'(sv_q);
	assign t_mag  = t_q[43]  ? 44'(-t_q)  : 44'(t_q);
	assign u_mag  = u_q[44]  ? 45'(-u_q)  : 45'(u_q);
	assign v_mag  = v_q[44]  ? 45'(-v_q)  : 45'(v_q);

	// series step: reciprocal quotient with one correction
	logic [8:0]  ser_den;
	logic [31:0] ser_rem, ser_quo;
	logic [30:0] ser_s_new;

	assign ser_den   = gtf_pkg::series_den(odd_q, kidx_q);
	assign ser_rem   = p_q - prod_q[31:0];
	assign ser_quo   = (ser_rem >= 32'(ser_den)) ? q0_q + 32'd1 : q0_q;
	assign ser_s_new = (ser_quo > 32'(gtf_pkg::Q30_ONE)) ? 31'd0
	                 : 31'(32'(gtf_pkg::Q30_ONE) - ser_quo);

	// rounding of products to Q30
	logic [63:0] prod_r30;
	assign prod_r30 = (prod_q + (64'd1 << 29)) >> 30;

	// mixing: round half away from zero to 2^-15
	logic [18:0] mix_m;
	assign mix_m = 19'((prod_q + 64'd32768) >> 16);

	// history of the side in work
	always_comb begin
		for (int i = 0; i < 4; i++)
			cur_h[i] = side_q ? imag_h[i] : real_h[i];
	end

	// pole multiply result and recursion combine
	logic [44:0] mp_mag;
	logic signed [46:0] mp_w, rec_base, rec_sum;

	assign mp_mag = 45'(prod_q[43:0]) + 45'(lowr_q);
	assign mp_w   = t_q[43] ? -$signed(47'(mp_mag)) : $signed(47'(mp_mag));

	always_comb begin
		case (st_q)
			3'd0:    rec_base = 47'(cur_h[2]) <<< 2;
			3'd1:    rec_base = (47'(cur_h[1]) <<< 2) + (47'(cur_h[1]) <<< 1);
			3'd2:    rec_base = 47'(cur_h[0]) <<< 2;
			3'd3:    rec_base = side_q ? 47'(mixi_q) : 47'(mixr_q);
			3'd4:    rec_base = 47'(cur_h[1]) <<< 2;
			3'd5:    rec_base = 47'(cur_h[0]);
			default: rec_base = '0;
		endcase
		rec_sum = (st_q <= 3'd2) ? rec_base - mp_w : rec_base + mp_w;
	end

	// gain product rounding and output saturation
	logic [47:0] bm_mag;
	logic signed [15:0] filt_sat;

	assign bm_mag = 48'((bacc_q + (112'd1 << 63)) >> 64);

	always_comb begin
		if (dneg_q)
			filt_sat = (bm_mag > 48'd32768) ? 16'sh8000 : 16'(-$signed(49'(bm_mag)));
		else
			filt_sat = (bm_mag > 48'd32767) ? 16'sh7FFF : 16'(bm_mag);
	end

	// square root bit step
	logic [32:0] sq_sum;
	assign sq_sum = 33'(sq_r_q) + 33'(sq_bit_q);

	// last phase of each state
	always_comb begin
		unique case (state_q)
			gtf_pkg::ST_ANGLE:   ph_end = 3'd3;
			gtf_pkg::ST_SERIES:  ph_end = 3'd5;
			gtf_pkg::ST_SIN_FIN: ph_end = 3'd1;
			gtf_pkg::ST_MIX:     ph_end = 3'd2;
			gtf_pkg::ST_REC:     ph_end = 3'd2;
			gtf_pkg::ST_DOUT:    ph_end = 3'd5;
			gtf_pkg::ST_GAIN:    ph_end = 3'd5;
			default:             ph_end = 3'd0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		ph_d    = (ph_q == ph_end) ? 3'd0 : ph_q + 3'd1;
		unique case (state_q)
			gtf_pkg::ST_IDLE:
				if (s_tvalid) state_d = gtf_pkg::ST_ANGLE;
			gtf_pkg::ST_ANGLE:
				if (ph_q == ph_end) state_d = gtf_pkg::ST_SERIES;
			gtf_pkg::ST_SERIES:
				if (ph_q == ph_end && kidx_q == 3'd0)
					state_d = odd_q ? gtf_pkg::ST_SIN_FIN : gtf_pkg::ST_QUAD;
			gtf_pkg::ST_SIN_FIN:
				if (ph_q == ph_end) state_d = gtf_pkg::ST_SERIES;
			gtf_pkg::ST_QUAD:
				state_d = gtf_pkg::ST_MIX;
			gtf_pkg::ST_MIX:
				if (ph_q == ph_end) state_d = gtf_pkg::ST_REC;
			gtf_pkg::ST_REC:
				if (ph_q == ph_end && st_q == 3'd6 && side_q) state_d = gtf_pkg::ST_DOUT;
			gtf_pkg::ST_DOUT:
				if (ph_q == ph_end) state_d = gtf_pkg::ST_GAIN;
			gtf_pkg::ST_GAIN:
				if (ph_q == ph_end) state_d = gtf_pkg::ST_SQRT;
			gtf_pkg::ST_SQRT:
				if (cnt_q == 4'd15) state_d = gtf_pkg::ST_WRITE;
			gtf_pkg::ST_WRITE:
				if (!out_valid_q || m_tready) state_d = gtf_pkg::ST_IDLE;
			default:
				state_d = gtf_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs: handshake and multiplier operands
	always_comb begin
		s_tready = (state_q == gtf_pkg::ST_IDLE);
		mul_a    = '0;
		mul_b    = '0;
		unique case (state_q)
			gtf_pkg::ST_ANGLE: begin
				if (ph_q == 3'd0) begin
					mul_a = 32'(angle_q[29:0]);
					mul_b = gtf_pkg::HALF_PI_Q30;
				end else if (ph_q == 3'd2) begin
					mul_a = 32'(a_q);
					mul_b = 32'(a_q);
				end
			end
			gtf_pkg::ST_SERIES: begin
				if (ph_q == 3'd0) begin
					mul_a = a2_q;
					mul_b = 32'(s_q);
				end else if (ph_q == 3'd2) begin
					mul_a = p_q;
					mul_b = gtf_pkg::series_recip(odd_q, kidx_q);
				end else if (ph_q == 3'd4) begin
					mul_a = q0_q;
					mul_b = 32'(ser_den);
				end
			end
			gtf_pkg::ST_SIN_FIN: begin
				if (ph_q == 3'd0) begin
					mul_a = 32'(a_q);
					mul_b = 32'(s_q);
				end
			end
			gtf_pkg::ST_MIX: begin
				if (ph_q == 3'd0) begin
					mul_a = 32'(x_mag);
					mul_b = 32'(cv_mag);
				end else if (ph_q == 3'd1) begin
					mul_a = 32'(x_mag);
					mul_b = 32'(sv_mag);
				end
			end
			gtf_pkg::ST_REC: begin
				if (ph_q == 3'd0) begin
					mul_a = t_mag[31:0];
					mul_b = pole_q;
				end else if (ph_q == 3'd1) begin
					mul_a = 32'(t_mag[43:32]);
					mul_b = pole_q;
				end
			end
			gtf_pkg::ST_DOUT: begin
				case (ph_q)
					3'd0: begin mul_a = u_mag[31:0];        mul_b = 32'(cv_mag); end
					3'd1: begin mul_a = 32'(u_mag[44:32]);  mul_b = 32'(cv_mag); end
					3'd2: begin mul_a = v_mag[31:0];        mul_b = 32'(sv_mag); end
					3'd3: begin mul_a = 32'(v_mag[44:32]);  mul_b = 32'(sv_mag); end
					default: ;
				endcase
			end
			gtf_pkg::ST_GAIN: begin
				case (ph_q)
					3'd0: begin mul_a = dmag_q[31:0];       mul_b = gain_q[31:0]; end
					3'd1: begin mul_a = dmag_q[31:0];       mul_b = 32'(gain_q[47:32]); end
					3'd2: begin mul_a = 32'(dmag_q[61:32]); mul_b = gain_q[31:0]; end
					3'd3: begin mul_a = 32'(dmag_q[61:32]); mul_b = 32'(gain_q[47:32]); end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// shared multiplier
	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
	end

	// control, configuration, phase and histories
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gtf_pkg::ST_IDLE;
			ph_q        <= '0;
			kidx_q      <= '0;
			odd_q       <= 1'b0;
			st_q        <= '0;
			side_q      <= 1'b0;
			cnt_q       <= '0;
			pole_q      <= '0;
			step_q      <= '0;
			gain_q      <= '0;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				real_h[i] <= '0;
				imag_h[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			ph_q    <= ph_d;

			// register writes
			if (cfg_wr_en) begin
				unique case (cfg_index)
					gtf_pkg::REG_POLE_DECAY:  pole_q <= cfg_data[31:0];
					gtf_pkg::REG_PHASE_STEP:  step_q <= cfg_data[31:0];
					gtf_pkg::REG_OUTPUT_GAIN: gain_q <= cfg_data;
					default: ;
				endcase
			end

			// phase advances once per accepted request
			if (s_tvalid && s_tready)
				phase_q <= phase_q + step_q;

			// series term counter
			if (state_q == gtf_pkg::ST_ANGLE && ph_q == 3'd3) begin
				kidx_q <= 3'd7;
				odd_q  <= 1'b1;
			end else if (state_q == gtf_pkg::ST_SIN_FIN && ph_q == 3'd1) begin
				kidx_q <= 3'd7;
				odd_q  <= 1'b0;
			end else if (state_q == gtf_pkg::ST_SERIES && ph_q == 3'd5) begin
				kidx_q <= kidx_q - 3'd1;
			end

			// recursion step and side
			if (state_q == gtf_pkg::ST_MIX && ph_q == 3'd2) begin
				st_q   <= '0;
				side_q <= 1'b0;
			end else if (state_q == gtf_pkg::ST_REC && ph_q == 3'd2) begin
				if (st_q == 3'd6) begin
					st_q   <= '0;
					side_q <= 1'b1;
					if (side_q) begin
						imag_h[3] <= imag_h[2];
						imag_h[2] <= imag_h[1];
						imag_h[1] <= imag_h[0];
						imag_h[0] <= newv_q;
					end else begin
						real_h[3] <= real_h[2];
						real_h[2] <= real_h[1];
						real_h[1] <= real_h[0];
						real_h[0] <= newv_q;
					end
				end else begin
					st_q <= st_q + 3'd1;
				end
			end

			// square root step counter
			if (state_q == gtf_pkg::ST_SQRT)
				cnt_q <= cnt_q + 4'd1;
			else
				cnt_q <= '0;

			// output register
			if (state_q == gtf_pkg::ST_WRITE && (!out_valid_q || m_tready))
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			gtf_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					x_q     <= s_tdata;
					angle_q <= {phase_q[31:30], phase_q[29:0] & ANGLE_MASK};
				end
			end
			gtf_pkg::ST_ANGLE: begin
				if (ph_q == 3'd1)
					a_q <= 31'(prod_r30);
				else if (ph_q == 3'd3) begin
					a2_q <= 32'(prod_r30);
					s_q  <= gtf_pkg::Q30_ONE;
				end
			end
			gtf_pkg::ST_SERIES: begin
				case (ph_q)
					3'd1: p_q  <= 32'(prod_r30);
					3'd3: q0_q <= prod_q[63:32];
					3'd5: begin
						s_q <= ser_s_new;
						if (kidx_q == 3'd0 && !odd_q)
							cq_q <= 18'((33'(ser_s_new) + 33'd8192) >> 14);
					end
					default: ;
				endcase
			end
			gtf_pkg::ST_SIN_FIN: begin
				if (ph_q == 3'd1) begin
					sq_q <= 18'((prod_r30 + 64'd8192) >> 14);
					s_q  <= gtf_pkg::Q30_ONE;
				end
			end
			gtf_pkg::ST_QUAD: begin
				// map first-quadrant values to the phase quadrant
				case (angle_q[31:30])
					2'd0: begin
						cv_q <= $signed({1'b0, cq_q});
						sv_q <= $signed({1'b0, sq_q});
					end
					2'd1: begin
						cv_q <= -$signed({1'b0, sq_q});
						sv_q <= $signed({1'b0, cq_q});
					end
					2'd2: begin
						cv_q <= -$signed({1'b0, cq_q});
						sv_q <= -$signed({1'b0, sq_q});
					end
					default: begin
						cv_q <= $signed({1'b0, sq_q});
						sv_q <= -$signed({1'b0, cq_q});
					end
				endcase
			end
			gtf_pkg::ST_MIX: begin
				if (ph_q == 3'd1) begin
					mixr_q <= (x_q[15] ^ cv_q[18]) ? -$signed({1'b0, mix_m})
					                               : $signed({1'b0, mix_m});
				end else if (ph_q == 3'd2) begin
					mixi_q <= (x_q[15] ^ sv_q[18]) ? $signed({1'b0, mix_m})
					                               : -$signed({1'b0, mix_m});
					t_q    <= 44'(real_h[3]);
				end
			end
			gtf_pkg::ST_REC: begin
				if (ph_q == 3'd1)
					lowr_q <= 33'((prod_q + 64'h8000_0000) >> 32);
				else if (ph_q == 3'd2) begin
					case (st_q)
						3'd3: begin
							newv_q <= gtf_pkg::sat40(rec_sum);
							t_q    <= 44'(cur_h[2]);
						end
						3'd6: begin
							if (side_q)
								v_q <= mp_w[44:0];
							else
								u_q <= mp_w[44:0];
							t_q   <= 44'(imag_h[3]);
							acc_q <= '0;
						end
						default: t_q <= gtf_pkg::sat44(rec_sum);
					endcase
				end
			end
			gtf_pkg::ST_DOUT: begin
				// d = u*cos - v*sin, signed accumulate of partial products
				case (ph_q)
					3'd1: acc_q <= (u_q[44] ^ cv_q[18]) ? acc_q - $signed(prod_q)
					                                    : acc_q + $signed(prod_q);
					3'd2: acc_q <= (u_q[44] ^ cv_q[18]) ? acc_q - $signed({prod_q[31:0], 32'd0})
					                                    : acc_q + $signed({prod_q[31:0], 32'd0});
					3'd3: acc_q <= (v_q[44] ^ sv_q[18]) ? acc_q + $signed(prod_q)
					                                    : acc_q - $signed(prod_q);
					3'd4: acc_q <= (v_q[44] ^ sv_q[18]) ? acc_q + $signed({prod_q[31:0], 32'd0})
					                                    : acc_q - $signed({prod_q[31:0], 32'd0});
					3'd5: begin
						dneg_q <= acc_q[63];
						dmag_q <= acc_q[63] ? 62'(-acc_q) : 62'(acc_q);
						bacc_q <= '0;
					end
					default: ;
				endcase
			end
			gtf_pkg::ST_GAIN: begin
				case (ph_q)
					3'd1: bacc_q <= bacc_q + 112'(prod_q);
					3'd2: bacc_q <= bacc_q + 112'({prod_q, 32'd0});
					3'd3: bacc_q <= bacc_q + 112'({prod_q, 32'd0});
					3'd4: bacc_q <= bacc_q + {prod_q[47:0], 64'd0};
					3'd5: begin
						filt_q   <= filt_sat;
						sq_v_q   <= (filt_sat > 16'sd0) ? (32'(filt_sat) << 17) : 32'd0;
						sq_r_q   <= '0;
						sq_bit_q <= 32'd1 << 30;
					end
					default: ;
				endcase
			end
			gtf_pkg::ST_SQRT: begin
				// one result bit per cycle
				if (33'(sq_v_q) >= sq_sum) begin
					sq_v_q <= 32'(33'(sq_v_q) - sq_sum);
					sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
				end else begin
					sq_r_q <= sq_r_q >> 1;
				end
				sq_bit_q <= sq_bit_q >> 2;
			end
			gtf_pkg::ST_WRITE: begin
				if (!out_valid_q || m_tready) begin
					out_filt_q <= filt_q;
					out_env_q  <= sq_r_q[15:0];
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_env_q, out_filt_q};

	// accepted request starts the angle computation
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == gtf_pkg::ST_ANGLE))
		else $error("request accepted without starting the sequence");

	// phase counter stays inside the longest state
	a_phase: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q <= 3'd5)
		else $error("phase counter out of range");

	// series partial sum stays within unity
	a_series: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gtf_pkg::ST_SERIES) |-> (s_q <= gtf_pkg::Q30_ONE))
		else $error("series partial sum above one");

	// no envelope for a non-positive output
	a_env: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && $signed(m_tdata[15:0]) <= 16'sd0) |-> (m_tdata[31:16] == 16'd0))
		else $error("envelope set for non-positive output");

	// a finished result always reaches the output register
	a_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gtf_pkg::ST_WRITE && !out_valid_q) |=> out_valid_q)
		else $error("result not written to output register");

endmodule
